// ----- src/dependency_cycle_check_defines.svh -----
// Assertion macros for the dependency cycle check block.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef DEPENDENCY_CYCLE_CHECK_DEFINES_SVH
`define DEPENDENCY_CYCLE_CHECK_DEFINES_SVH

// Condition now implies a condition in the next cycle
`define DCC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dependency_cycle_check: next-cycle property failed");

// Condition now implies a condition in the same cycle
`define DCC_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dependency_cycle_check: same-cycle property failed");

`endif

// ----- src/dcc_pkg.sv -----
// Shared types and constants of the dependency cycle check block.
// No dependencies; used by dcc_ctrl, dcc_dpath, the top level and the checker.
`default_nettype none

package dcc_pkg;

  // Field widths fixed by the interface
  localparam int TASK_W   = 5;
  localparam int CNT_W    = 6;
  localparam int CMP_W    = 7;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int MAX_TASKS_DEF = 32;

  // Command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register index, taken from paddr bit 2
  localparam logic REG_TASK_COUNT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WR,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic add_rd;
    logic add_wr;
    logic clear;
    logic chk_start;
    logic chk_issue;
    logic pass_start;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic edge_ok;
    logic n_zero;
    logic issue_last;
    logic all_done;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/dcc_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module dcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wen,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             ren,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/dcc_ctrl.sv -----
// Controller of the dependency cycle check: command decode and pass sequencing.
// Depends on dcc_pkg.
`default_nettype none

module dcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_cmd,
  input  wire dcc_pkg::dp_stat_t stat,
  output logic                   in_stall,
  output dcc_pkg::ctrl_cmd_t     cmd
);

  dcc_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      dcc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_cmd)
            dcc_pkg::CMD_ADD: begin
              // out-of-range edges are dropped
              if (stat.edge_ok) begin
                cmd.add_rd = 1'b1;
                state_nxt  = dcc_pkg::S_ADD_WR;
              end
            end
            dcc_pkg::CMD_CHECK: begin
              cmd.chk_start = 1'b1;
              state_nxt     = stat.n_zero ? dcc_pkg::S_FINISH : dcc_pkg::S_SCAN;
            end
            dcc_pkg::CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      dcc_pkg::S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = dcc_pkg::S_IDLE;
      end
      dcc_pkg::S_SCAN: begin
        cmd.chk_issue = 1'b1;
        if (stat.issue_last) begin
          state_nxt = dcc_pkg::S_DRAIN;
        end
      end
      dcc_pkg::S_DRAIN: begin
        // last row of the pass is evaluated here
        state_nxt = dcc_pkg::S_DECIDE;
      end
      dcc_pkg::S_DECIDE: begin
        if (stat.all_done || !stat.found) begin
          state_nxt = dcc_pkg::S_FINISH;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = dcc_pkg::S_SCAN;
        end
      end
      dcc_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = dcc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dcc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/dcc_dpath.sv -----
// Datapath of the dependency cycle check: edge RAM, row valid bits,
// resolved mask, counters and the result register. Depends on dcc_pkg, dcc_ram.
`default_nettype none

module dcc_dpath #(
  parameter int MAX_TASKS = dcc_pkg::MAX_TASKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dcc_pkg::ctrl_cmd_t         cmd,
  input  wire logic [dcc_pkg::CNT_W-1:0]  task_count,
  input  wire logic [dcc_pkg::TASK_W-1:0] in_waiting_task,
  input  wire logic [dcc_pkg::TASK_W-1:0] in_prerequisite_task,
  input  wire logic                       out_stall,
  output dcc_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  output logic                            out_has_cycle,
  output logic [dcc_pkg::CNT_W-1:0]       out_resolved_count
);

  localparam int TW   = $clog2(MAX_TASKS);
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = dcc_pkg::CMP_W;
  localparam int CNTW = dcc_pkg::CNT_W;

  logic [CW-1:0]        n_eff;
  logic [MAX_TASKS-1:0] act;

  logic [MAX_TASKS-1:0] row_vld_r;
  logic                 vld_q_r;
  logic [TW-1:0]        rd_idx_r;
  logic                 eval_vld_r;
  logic [TW-1:0]        eval_idx_r;
  logic [TW-1:0]        w_r, p_r;
  logic [MAX_TASKS-1:0] res_r;
  logic [CW-1:0]        done_r;
  logic                 found_r;
  logic                 out_vld_r;
  logic                 out_cyc_r;
  logic [CNTW-1:0]      out_cnt_r;

  logic                 ram_ren;
  logic [TW-1:0]        ram_raddr;
  logic [MAX_TASKS-1:0] ram_rdata;
  logic [MAX_TASKS-1:0] ram_wdata;
  logic [MAX_TASKS-1:0] row;
  logic                 hit;

  // Effective task count, clamped to the table size
  assign n_eff = (CMPW'(task_count) > CMPW'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(task_count);

  // Active task mask
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      act[i] = (CMPW'(i) < CMPW'(n_eff));
    end
  end

  // Row read port: edge insert or pass scan
  assign ram_ren   = cmd.add_rd | cmd.chk_issue;
  assign ram_raddr = cmd.add_rd ? TW'(in_waiting_task) : rd_idx_r;

  // A row never written since reset or clear reads as empty
  assign row       = vld_q_r ? ram_rdata : '0;
  assign ram_wdata = row | ({{(MAX_TASKS-1){1'b0}}, 1'b1} << p_r);

  dcc_ram #(
    .WIDTH (MAX_TASKS),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .wen   (cmd.add_wr),
    .waddr (w_r),
    .wdata (ram_wdata),
    .ren   (ram_ren),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Task resolves when unresolved and all its active prerequisites are resolved
  assign hit = eval_vld_r && !res_r[eval_idx_r] && ((row & act & ~res_r) == '0);

  // Row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.clear) begin
      row_vld_r <= '0;
    end else if (cmd.add_wr) begin
      row_vld_r[w_r] <= 1'b1;
    end
  end

  // Read-side tracking and edge operands
  always_ff @(posedge clk) begin
    if (ram_ren) begin
      vld_q_r <= row_vld_r[ram_raddr];
    end
    if (cmd.add_rd) begin
      w_r <= TW'(in_waiting_task);
      p_r <= TW'(in_prerequisite_task);
    end
    eval_idx_r <= rd_idx_r;
  end

  // Scan control and resolution state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      res_r      <= '0;
      done_r     <= '0;
      found_r    <= 1'b0;
    end else begin
      eval_vld_r <= cmd.chk_issue;
      if (cmd.chk_start || cmd.pass_start) begin
        rd_idx_r <= '0;
        found_r  <= 1'b0;
      end else if (cmd.chk_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (cmd.chk_start) begin
        res_r  <= '0;
        done_r <= '0;
      end else if (hit) begin
        res_r[eval_idx_r] <= 1'b1;
        done_r            <= done_r + 1'b1;
        found_r           <= 1'b1;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cyc_r <= (CMPW'(done_r) < CMPW'(n_eff));
      out_cnt_r <= CNTW'(done_r);
    end
  end

  // Status to the controller
  always_comb begin
    stat.edge_ok    = (CMPW'(in_waiting_task) < CMPW'(n_eff)) &&
                      (CMPW'(in_prerequisite_task) < CMPW'(n_eff));
    stat.n_zero     = (n_eff == '0);
    stat.issue_last = (CMPW'(rd_idx_r) == (CMPW'(n_eff) - 1'b1));
    stat.all_done   = (CMPW'(done_r) >= CMPW'(n_eff));
    stat.found      = found_r;
    stat.out_free   = !out_vld_r || !out_stall;
  end

  assign out_valid          = out_vld_r;
  assign out_has_cycle      = out_cyc_r;
  assign out_resolved_count = out_cnt_r;

endmodule

`default_nettype wire

// ----- src/dependency_cycle_check.sv -----
// Top level of the dependency cycle check: configuration port and glue.
// Depends on dcc_pkg, dcc_ctrl, dcc_dpath (and through it dcc_ram).
//
// Usage:
//  - Input channel (in_valid/in_stall) carries command words: add an edge
//    (waiting task needs prerequisite task), run a check, or clear the graph.
//  - Result channel (out_valid/out_stall) carries one word per check:
//    has_cycle and resolved_count. Add and clear give no result.
//  - task_count sits at byte address 0 of the APB-style port; write it only when idle.
//  - Adding an edge reads the row, then writes it back in the edge RAM
//    (S_IDLE, then S_ADD_WR); clear and a dropped out-of-range edge stay in S_IDLE.
//  - A check runs Kahn passes, each reading the n active rows from the edge
//    RAM one per cycle, then a drain and a decision state; there are at most n
//    passes, and out_valid rises when S_FINISH loads the result word.
//    With task_count 0 the check goes straight to S_FINISH.
//  - in_stall stays high while an add or check is in progress.
//  - If the receiver stalls, the result word is held in the output register
//    and a following add or clear is still taken; a later check waits for it.
//  - Reset (rst_n low, synchronous) empties the graph at once through per-row
//    valid bits, clears task_count and drops any pending result.
`default_nettype none

module dependency_cycle_check #(
  parameter int MAX_TASKS = dcc_pkg::MAX_TASKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [dcc_pkg::TASK_W-1:0] in_waiting_task,
  input  wire logic [dcc_pkg::TASK_W-1:0] in_prerequisite_task,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_has_cycle,
  output logic [dcc_pkg::CNT_W-1:0]       out_resolved_count,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [dcc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [dcc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dcc_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  logic [dcc_pkg::CNT_W-1:0] task_count_r;
  logic                      cfg_wr;
  dcc_pkg::ctrl_cmd_t        cmd;
  dcc_pkg::dp_stat_t         stat;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2] == dcc_pkg::REG_TASK_COUNT)) begin
      task_count_r <= cfg_pwdata[dcc_pkg::CNT_W-1:0];
    end
  end

  // Read back
  assign cfg_prdata = (cfg_paddr[2] == dcc_pkg::REG_TASK_COUNT) ?
                      dcc_pkg::CFG_DW'(task_count_r) : '0;

  dcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dcc_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .task_count           (task_count_r),
    .in_waiting_task      (in_waiting_task),
    .in_prerequisite_task (in_prerequisite_task),
    .out_stall            (out_stall),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_has_cycle        (out_has_cycle),
    .out_resolved_count   (out_resolved_count)
  );

endmodule

`default_nettype wire

// ----- src/dcc_checker.sv -----
// Port-level checker for the dependency cycle check, bound to the top level.
// Depends on dcc_pkg and dependency_cycle_check_defines.svh.
`default_nettype none
`include "dependency_cycle_check_defines.svh"

module dcc_checker #(
  parameter int MAX_TASKS = dcc_pkg::MAX_TASKS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [1:0]                 in_cmd,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_has_cycle,
  input wire logic [dcc_pkg::CNT_W-1:0]  out_resolved_count
);

  localparam int CMPW = dcc_pkg::CMP_W;

  // An accepted check keeps the input side busy until its result is out
  `DCC_ASSERT_NEXT(a_check_busy, in_valid && !in_stall && (in_cmd == dcc_pkg::CMD_CHECK), in_stall)

  // A new result word only appears after the block was busy
  `DCC_ASSERT_SAME(a_result_after_busy, $rose(out_valid), $past(in_stall))

  // A cycle leaves at least one task unresolved
  `DCC_ASSERT_SAME(a_cycle_count, out_valid && out_has_cycle, CMPW'(out_resolved_count) < CMPW'(MAX_TASKS))

  // A stalled result word holds
  `DCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_has_cycle) && $stable(out_resolved_count))

endmodule

bind dependency_cycle_check dcc_checker #(
  .MAX_TASKS (MAX_TASKS)
) u_dcc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_cmd             (in_cmd),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_has_cycle      (out_has_cycle),
  .out_resolved_count (out_resolved_count)
);

`default_nettype wire
